>>> rtl/rvp_pkg.sv
// shared types and constants of the rtp vp9 packetizer
// no dependencies
package rvp_pkg;

   localparam int HDR_LEN     = 13;
   localparam int IDX_W       = 4;
   localparam int CAP_W       = 12;
   localparam int MPS_W       = 13;
   localparam int LEN_W       = 21;
   localparam int TS_W        = 32;
   localparam int SEQ_W       = 16;
   localparam int PT_W        = 7;
   localparam int SSRC_W      = 32;
   localparam int PKT_W       = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [7:0] MARKER_BIT       = 8'h80;
   localparam logic [7:0] DESC_START       = 8'h08;
   localparam logic [7:0] DESC_END         = 8'h04;

   localparam logic [MPS_W-1:0] MPS_MIN = 13'd2;
   localparam logic [MPS_W-1:0] MPS_MAX = 13'd4096;

   localparam logic [PT_W-1:0]   PT_RESET   = 7'd96;
   localparam logic [SSRC_W-1:0] SSRC_RESET = 32'd12345678;
   localparam logic [MPS_W-1:0]  MPS_RESET  = 13'd1200;
   localparam logic [SEQ_W-1:0]  SEQ_RESET  = 16'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_TYPE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_SRC_ID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SEQUENCE = 2'd3;

   // header byte positions
   localparam logic [IDX_W-1:0] IDX_VERSION = 4'd0;
   localparam logic [IDX_W-1:0] IDX_PT      = 4'd1;
   localparam logic [IDX_W-1:0] IDX_SEQ_HI  = 4'd2;
   localparam logic [IDX_W-1:0] IDX_SEQ_LO  = 4'd3;
   localparam logic [IDX_W-1:0] IDX_TS_3    = 4'd4;
   localparam logic [IDX_W-1:0] IDX_TS_2    = 4'd5;
   localparam logic [IDX_W-1:0] IDX_TS_1    = 4'd6;
   localparam logic [IDX_W-1:0] IDX_TS_0    = 4'd7;
   localparam logic [IDX_W-1:0] IDX_SSRC_3  = 4'd8;
   localparam logic [IDX_W-1:0] IDX_SSRC_2  = 4'd9;
   localparam logic [IDX_W-1:0] IDX_SSRC_1  = 4'd10;
   localparam logic [IDX_W-1:0] IDX_SSRC_0  = 4'd11;
   localparam logic [IDX_W-1:0] IDX_DESC    = 4'd12;
   localparam logic [IDX_W-1:0] IDX_PAYLOAD = 4'd13;

   typedef struct packed {
      logic [7:0]       data;
      logic             hdr;
      logic             last_pkt;
      logic             first_pkt;
      logic             pkt_end;
      logic [SEQ_W-1:0] seq;
      logic [TS_W-1:0]  ts;
   } cmd_type;

endpackage

>>> rtl/rvp_front.sv
// front part: frame and packet bookkeeping, one command per item that gives results
// depends on rvp_pkg
module rvp_front import rvp_pkg::*; #(
   parameter int MAX_PACKETS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             in_ready,
   input  logic [7:0]       in_byte,
   input  logic             in_start,
   input  logic [LEN_W-1:0] in_length,
   input  logic [TS_W-1:0]  in_ts,
   input  logic [MPS_W-1:0] max_payload,
   input  logic             seq_load,
   input  logic [SEQ_W-1:0] seq_value,
   output logic             push,
   output cmd_type          cmd
);

   localparam logic [PKT_W-1:0] PKT_LIMIT = PKT_W'(MAX_PACKETS);
   localparam logic [PKT_W-1:0] PKT_SAT   = {PKT_W{1'b1}};

   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [CAP_W-1:0] pc_ff, pc_in;
   logic [PKT_W-1:0] ps_ff, ps_in;
   logic [TS_W-1:0]  ts_ff, ts_in;
   logic             fp_ff, fp_in;

   logic [MPS_W-1:0] mps;
   logic [CAP_W-1:0] cap;
   logic [LEN_W-1:0] br, br_dec;
   logic [CAP_W-1:0] pc, pc_inc;
   logic [PKT_W-1:0] ps;
   logic [TS_W-1:0]  ts;
   logic             fp, fire, hdr, last_pkt, is_end;

   always_comb begin
      if (max_payload < MPS_MIN) begin
         mps = MPS_MIN;
      end else if (max_payload > MPS_MAX) begin
         mps = MPS_MAX;
      end else begin
         mps = max_payload;
      end
      cap = CAP_W'(mps - MPS_W'(1));
   end

   assign fire = in_valid && in_ready;

   always_comb begin
      br       = in_start ? in_length : rem_ff;
      pc       = in_start ? '0 : pc_ff;
      ps       = in_start ? '0 : ps_ff;
      fp       = in_start ? 1'b1 : fp_ff;
      ts       = in_start ? in_ts : ts_ff;
      br_dec   = br - LEN_W'(1);
      pc_inc   = pc + CAP_W'(1);
      hdr      = (pc == '0);
      last_pkt = (br <= LEN_W'(cap));
      is_end   = (br_dec == '0) || (pc_inc >= cap);

      seq_in = seq_ff;
      rem_in = rem_ff;
      pc_in  = pc_ff;
      ps_in  = ps_ff;
      ts_in  = ts_ff;
      fp_in  = fp_ff;
      push   = 1'b0;

      if (fire) begin
         rem_in = br;
         pc_in  = pc;
         ps_in  = ps;
         ts_in  = ts;
         fp_in  = fp;
         if (br != '0) begin
            rem_in = br_dec;
            if (!(hdr && ps >= PKT_LIMIT)) begin
               push  = 1'b1;
               pc_in = is_end ? '0 : pc_inc;
               if (is_end && ps != PKT_SAT) begin
                  ps_in = ps + PKT_W'(1);
               end
               if (hdr) begin
                  fp_in  = 1'b0;
                  seq_in = seq_ff + SEQ_W'(1);
               end
            end
         end
      end
      if (seq_load) begin
         seq_in = seq_value;
      end
   end

   always_comb begin
      cmd.data      = in_byte;
      cmd.hdr       = hdr;
      cmd.last_pkt  = last_pkt;
      cmd.first_pkt = fp;
      cmd.pkt_end   = is_end;
      cmd.seq       = seq_ff;
      cmd.ts        = ts;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_RESET;
         rem_ff <= '0;
         pc_ff  <= '0;
         ps_ff  <= '0;
         ts_ff  <= '0;
         fp_ff  <= 1'b1;
      end else begin
         seq_ff <= seq_in;
         rem_ff <= rem_in;
         pc_ff  <= pc_in;
         ps_ff  <= ps_in;
         ts_ff  <= ts_in;
         fp_ff  <= fp_in;
      end
   end

endmodule

>>> rtl/rvp_queue.sv
// short command queue between front and back
// depends on rvp_pkg
module rvp_queue import rvp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]    cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full      = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> rtl/rvp_emit.sv
// back part: per command, header bytes if hdr, then the payload byte
// depends on rvp_pkg
module rvp_emit import rvp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   input  logic [PT_W-1:0]   payload_type,
   input  logic [SSRC_W-1:0] ssrc,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_byte,
   output logic              out_begin,
   output logic              out_end,
   output logic              out_last
);

   cmd_type          cur_ff, cur_in;
   logic             vld_ff, vld_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             fire, at_payload;

   assign fire       = vld_ff && out_ready;
   assign at_payload = (idx_ff == IDX_PAYLOAD);
   assign cmd_pop    = !vld_ff || (fire && at_payload);

   always_comb begin
      cur_in = cur_ff;
      vld_in = vld_ff;
      idx_in = idx_ff;
      if (cmd_pop) begin
         cur_in = cmd;
         vld_in = cmd_valid;
         idx_in = cmd.hdr ? IDX_VERSION : IDX_PAYLOAD;
      end else if (fire) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      case (idx_ff)
         IDX_VERSION: out_byte = RTP_VERSION_BYTE;
         IDX_PT:      out_byte = {1'b0, payload_type} | (cur_ff.last_pkt ? MARKER_BIT : 8'h00);
         IDX_SEQ_HI:  out_byte = cur_ff.seq[15:8];
         IDX_SEQ_LO:  out_byte = cur_ff.seq[7:0];
         IDX_TS_3:    out_byte = cur_ff.ts[31:24];
         IDX_TS_2:    out_byte = cur_ff.ts[23:16];
         IDX_TS_1:    out_byte = cur_ff.ts[15:8];
         IDX_TS_0:    out_byte = cur_ff.ts[7:0];
         IDX_SSRC_3:  out_byte = ssrc[31:24];
         IDX_SSRC_2:  out_byte = ssrc[23:16];
         IDX_SSRC_1:  out_byte = ssrc[15:8];
         IDX_SSRC_0:  out_byte = ssrc[7:0];
         IDX_DESC:    out_byte = (cur_ff.first_pkt ? DESC_START : 8'h00)
                                 | (cur_ff.last_pkt ? DESC_END : 8'h00);
         default:     out_byte = cur_ff.data;
      endcase
   end

   assign out_valid = vld_ff;
   assign out_begin = (idx_ff == IDX_VERSION);
   assign out_end   = at_payload && cur_ff.pkt_end;
   assign out_last  = at_payload;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= IDX_PAYLOAD;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

endmodule

>>> rtl/rtp_vp9_packetizer.sv
// top level of the rtp vp9 packetizer: configuration registers, front, queue and back
// depends on rvp_pkg, rvp_front, rvp_queue, rvp_emit
//
// Takes one frame byte per cycle while the command queue has room and gives one
// output byte per cycle while the output is ready. A byte that continues an open
// packet yields one result; a byte that opens a packet yields 14 (13 header bytes,
// then the byte). The output side is set by the back end's byte counter; a
// four-entry command queue lets the input keep accepting payload bytes while a
// header is going out, and the input stalls only when that queue is full. Dropped
// bytes are taken at one per cycle with no result.
module rtp_vp9_packetizer import rvp_pkg::*; #(
   parameter int MAX_PACKETS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // data_byte, frame_length, frame_timestamp
   input  logic                  req_tuser,  // frame_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // out_byte
   output logic [1:0]            rsp_tuser,  // packet_begin, packet_end
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [PT_W-1:0]   pt_ff, pt_in;
   logic [SSRC_W-1:0] ssrc_ff, ssrc_in;
   logic [MPS_W-1:0]  mps_ff, mps_in;
   logic              seq_load;
   logic              push, full, q_valid, q_pop;
   cmd_type           push_cmd, head;

   always_comb begin
      pt_in    = pt_ff;
      ssrc_in  = ssrc_ff;
      mps_in   = mps_ff;
      seq_load = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_PAYLOAD_TYPE:   pt_in    = csr_wdata[PT_W-1:0];
            CSR_STREAM_SRC_ID:  ssrc_in  = csr_wdata[SSRC_W-1:0];
            CSR_MAX_PAYLOAD:    mps_in   = csr_wdata[MPS_W-1:0];
            CSR_START_SEQUENCE: seq_load = 1'b1;
            default:            seq_load = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff   <= PT_RESET;
         ssrc_ff <= SSRC_RESET;
         mps_ff  <= MPS_RESET;
      end else begin
         pt_ff   <= pt_in;
         ssrc_ff <= ssrc_in;
         mps_ff  <= mps_in;
      end
   end

   assign req_tready = !full;

   rvp_front #(
      .MAX_PACKETS(MAX_PACKETS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata[7:0]),
      .in_start    (req_tuser),
      .in_length   (req_tdata[28:8]),
      .in_ts       (req_tdata[60:29]),
      .max_payload (mps_ff),
      .seq_load    (seq_load),
      .seq_value   (csr_wdata[SEQ_W-1:0]),
      .push        (push),
      .cmd         (push_cmd)
   );

   rvp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (head)
   );

   rvp_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (q_valid),
      .cmd          (head),
      .cmd_pop      (q_pop),
      .payload_type (pt_ff),
      .ssrc         (ssrc_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (rsp_tdata),
      .out_begin    (rsp_tuser[0]),
      .out_end      (rsp_tuser[1]),
      .out_last     (rsp_tlast)
   );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for rtp_vp9_packetizer: directed and random frames are sent,
// the expected packet bytes are predicted per item and checked against the output stream
// depends on rvp_pkg and the rtp_vp9_packetizer rtl
module tb_top import rvp_pkg::*;;

   localparam int PKT_LIMIT   = 64;
   localparam int DRAIN       = 24;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [7:0] value;
      logic       pkt_begin;
      logic       pkt_end;
      logic       run_last;
   } rtp_byte_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predictor copy of registers and packet state
   logic [PT_W-1:0]   cfg_pt        = PT_RESET;
   logic [SSRC_W-1:0] cfg_ssrc      = SSRC_RESET;
   logic [MPS_W-1:0]  cfg_mps       = MPS_RESET;
   logic [SEQ_W-1:0]  cfg_start_seq = SEQ_RESET;
   logic [SEQ_W-1:0]  seq_count     = SEQ_RESET;
   logic [LEN_W-1:0]  bytes_left    = '0;
   logic [CAP_W-1:0]  pkt_fill      = '0;
   logic [PKT_W-1:0]  pkts_done     = '0;
   logic [TS_W-1:0]   frame_ts      = '0;
   logic              first_pkt     = 1'b1;

   rtp_byte_type expected_bytes[$];

   int err_count     = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int items_counted = 0;

   rtp_vp9_packetizer #(.MAX_PACKETS(PKT_LIMIT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // data_byte, frame_length, frame_timestamp
      .req_tuser  (req_tuser),   // frame_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // out_byte
      .rsp_tuser  (rsp_tuser),   // packet_begin, packet_end
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void expect_byte(input logic [7:0] v, input logic b, input logic e,
                                       input logic l);
      rtp_byte_type o;
      o.value     = v;
      o.pkt_begin = b;
      o.pkt_end   = e;
      o.run_last  = l;
      expected_bytes.push_back(o);
   endfunction

   // returns the number of output bytes this frame byte causes
   function automatic int packetize_byte(input logic [7:0] b, input logic fs,
                                         input logic [LEN_W-1:0] len,
                                         input logic [TS_W-1:0] ts);
      int unsigned cap;
      logic        last_pkt;
      logic        done;
      logic [7:0]  desc;
      int          count;
      count = 0;
      if (cfg_mps < MPS_MIN) cap = 1;
      else if (cfg_mps > MPS_MAX) cap = MPS_MAX - 1;
      else cap = cfg_mps - 1;
      if (fs) begin
         bytes_left = len;
         frame_ts   = ts;
         pkts_done  = '0;
         pkt_fill   = '0;
         first_pkt  = 1'b1;
      end
      if (bytes_left == 0) return 0;
      if (pkt_fill == 0) begin
         if (pkts_done >= PKT_LIMIT) begin
            bytes_left = bytes_left - 1'b1;
            return 0;
         end
         last_pkt = (bytes_left <= cap);
         desc = (first_pkt ? DESC_START : 8'h00) | (last_pkt ? DESC_END : 8'h00);
         expect_byte(RTP_VERSION_BYTE, 1'b1, 1'b0, 1'b0);
         expect_byte((last_pkt ? MARKER_BIT : 8'h00) | {1'b0, cfg_pt}, 1'b0, 1'b0, 1'b0);
         expect_byte(seq_count[15:8], 1'b0, 1'b0, 1'b0);
         expect_byte(seq_count[7:0], 1'b0, 1'b0, 1'b0);
         expect_byte(frame_ts[31:24], 1'b0, 1'b0, 1'b0);
         expect_byte(frame_ts[23:16], 1'b0, 1'b0, 1'b0);
         expect_byte(frame_ts[15:8], 1'b0, 1'b0, 1'b0);
         expect_byte(frame_ts[7:0], 1'b0, 1'b0, 1'b0);
         expect_byte(cfg_ssrc[31:24], 1'b0, 1'b0, 1'b0);
         expect_byte(cfg_ssrc[23:16], 1'b0, 1'b0, 1'b0);
         expect_byte(cfg_ssrc[15:8], 1'b0, 1'b0, 1'b0);
         expect_byte(cfg_ssrc[7:0], 1'b0, 1'b0, 1'b0);
         expect_byte(desc, 1'b0, 1'b0, 1'b0);
         count     = HDR_LEN;
         first_pkt = 1'b0;
         seq_count = seq_count + 1'b1;
      end
      bytes_left = bytes_left - 1'b1;
      pkt_fill   = pkt_fill + 1'b1;
      done = (bytes_left == 0) || (pkt_fill >= cap);
      expect_byte(b, 1'b0, done, 1'b1);
      if (done) begin
         pkt_fill = '0;
         if (pkts_done != 7'd127) pkts_done = pkts_done + 1'b1;
      end
      return count + 1;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic fs, input logic [LEN_W-1:0] len,
                            input logic [TS_W-1:0] ts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, ts, len, b};
      req_tuser  <= fs;
      do @(posedge clock); while (req_tready !== 1'b1);
      void'(packetize_byte(b, fs, len, ts));
      items_counted++;
   endtask

   // frame start on the first byte, garbage length and timestamp on the rest
   task automatic send_frame(input logic [LEN_W-1:0] len, input int n);
      logic [TS_W-1:0] ts;
      ts = $urandom;
      for (int i = 0; i < n; i++) begin
         if (i == 0) send_byte(8'($urandom), 1'b1, len, ts);
         else send_byte(8'($urandom), 1'b0, LEN_W'($urandom), $urandom);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_PAYLOAD_TYPE:  cfg_pt   = value[PT_W-1:0];
         CSR_STREAM_SRC_ID: cfg_ssrc = value[SSRC_W-1:0];
         CSR_MAX_PAYLOAD:   cfg_mps  = value[MPS_W-1:0];
         CSR_START_SEQUENCE: begin
            cfg_start_seq = value[SEQ_W-1:0];
            seq_count     = cfg_start_seq;
         end
         default: ;
      endcase
   endtask

   // mask bits follow the register indexes
   task automatic configure(input logic [3:0] mask, input logic [31:0] pt,
                            input logic [31:0] ssrc, input logic [31:0] mps,
                            input logic [31:0] seq);
      wait_idle();
      if (mask[CSR_PAYLOAD_TYPE]) write_reg(CSR_PAYLOAD_TYPE, pt);
      if (mask[CSR_STREAM_SRC_ID]) write_reg(CSR_STREAM_SRC_ID, ssrc);
      if (mask[CSR_MAX_PAYLOAD]) write_reg(CSR_MAX_PAYLOAD, mps);
      if (mask[CSR_START_SEQUENCE]) write_reg(CSR_START_SEQUENCE, seq);
      csr_we <= 1'b0;
   endtask

   task automatic test_defaults();
      send_byte(8'h5A, 1'b0, 21'd7, 32'h0000_0000);        // no open frame
      send_byte(8'h11, 1'b1, 21'd0, 32'h1234_5678);        // zero length
      send_byte(8'h00, 1'b1, 21'd3, 32'hFFFF_FFFF);
      send_byte(8'hFF, 1'b0, 21'h1F_FFFF, 32'h0000_0000);
      send_byte(8'hA5, 1'b0, 21'd0, 32'h0000_0000);
      send_byte(8'h3C, 1'b0, 21'd0, 32'h0000_0000);        // past frame end
   endtask

   task automatic test_register_extremes();
      configure(4'b1111, 32'h0000_007F, 32'hFFFF_FFFF, 32'd2, 32'h0000_FFFF);
      send_frame(21'd3, 3);                                // sequence wraps
      configure(4'b1111, 32'hFFFF_FF80, 32'h0000_0000, 32'd4096, 32'h0000_0000);
      send_frame(21'd5, 5);
      configure(4'b0100, 32'h0, 32'h0, 32'd1, 32'h0);
      send_frame(21'd2, 2);
      configure(4'b0100, 32'h0, 32'h0, 32'd0, 32'h0);
      send_frame(21'd1, 1);
      configure(4'b0100, 32'h0, 32'h0, 32'h0000_1FFF, 32'h0);
      send_frame(21'd3, 3);
   endtask

   task automatic test_frame_restart();
      configure(4'b0100, 32'h0, 32'h0, 32'd4, 32'h0);
      send_frame(21'd10, 5);
      send_frame(21'h1F_FFFF, 2);
      send_frame(21'd2, 2);
   endtask

   task automatic test_packet_limit();
      configure(4'b0100, 32'h0, 32'h0, 32'd2, 32'h0);
      send_frame(21'(PKT_LIMIT + 3), PKT_LIMIT + 3);
      send_frame(21'd2, 2);
   endtask

   task automatic test_back_pressure();
      configure(4'b0100, 32'h0, 32'h0, 32'd3, 32'h0);
      hold_request = 400;
      send_frame(21'd40, 40);
      wait_idle();
      send_frame(21'd6, 6);
   endtask

   task automatic test_random(input int n, input int idle, input int stall,
                              input logic [31:0] mps, input logic [3:0] mask);
      int target;
      int kind;
      int len;
      configure(mask, $urandom, $urandom, mps, $urandom);
      send_idle_pct = idle;
      stall_pct     = stall;
      target = items_counted + n;
      while (items_counted < target) begin
         kind = $urandom_range(99);
         if (kind < 78) begin
            len = (kind < 6) ? $urandom_range(200, 31) : $urandom_range(30, 1);
            send_frame(21'(len), len);
         end else if (kind < 88) begin
            send_frame(21'($urandom_range(2097151)), $urandom_range(6, 1));
         end else if (kind < 95) begin
            send_byte(8'($urandom), 1'b0, LEN_W'($urandom), $urandom);
         end else begin
            send_byte(8'($urandom), 1'b1, '0, $urandom);
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_output
      rtp_byte_type exp_b;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            err_count++;
            if (err_count <= 40)
               $display("%0t: unexpected item byte %h begin %b end %b last %b", $time,
                        rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast);
         end else begin
            exp_b = expected_bytes.pop_front();
            if (exp_b.value !== rsp_tdata || exp_b.pkt_begin !== rsp_tuser[0] ||
                exp_b.pkt_end !== rsp_tuser[1] || exp_b.run_last !== rsp_tlast) begin
               err_count++;
               if (err_count <= 40)
                  $display("%0t: expected %h b%b e%b l%b, got %h b%b e%b l%b",
                           $time, exp_b.value, exp_b.pkt_begin, exp_b.pkt_end,
                           exp_b.run_last, rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL rtp_vp9_packetizer");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_register_extremes();
      test_frame_restart();
      test_packet_limit();
      test_back_pressure();
      test_random(50, 0, 0, $urandom_range(8, 2), 4'b1111);
      test_random(50, 54, 0, 32'h0000_1FFF, 4'b0111);
      test_random(50, 0, 54, $urandom_range(40, 2), 4'b1111);
      test_random(50, 16, 16, $urandom_range(16, 9), 4'b1011);
      wait_idle();
      if (err_count == 0) begin
         $display("PASS rtp_vp9_packetizer");
      end else begin
         $display("FAIL rtp_vp9_packetizer");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/rvp_pkg.sv
rtl/rvp_front.sv
rtl/rvp_queue.sv
rtl/rvp_emit.sv
rtl/rtp_vp9_packetizer.sv
tb/sv/tb_top.sv
